// File: design/ptw_pkg.sv
// Shared types and constants for the page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int unsigned VA_W       = 48;
    localparam int unsigned PA_W       = 52;
    localparam int unsigned FRAME_W    = 40;
    localparam int unsigned ENTRY_W    = 64;
    localparam int unsigned LEVEL_W    = 3;
    localparam int unsigned PAGE_BITS  = 12;
    localparam int unsigned IDX_BITS   = 9;
    localparam int unsigned ENTRY_SH   = 3;    // 8-byte entries
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = FRAME_W;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RESP  = 1'b1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_LEVEL = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVELS_FOUR  = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVELS_THREE = 3'd3;

    typedef struct packed {
        logic               cmd;
        logic [VA_W-1:0]    virtual_address;
        logic [ENTRY_W-1:0] entry_data;
    } t_ptw_in;

    typedef struct packed {
        logic               kind;
        logic [PA_W-1:0]    read_address;
        logic [FRAME_W-1:0] frame;
    } t_ptw_out;

    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level_left;
        logic [PA_W-1:0]    table_address;
        logic [VA_W-1:0]    latched_address;
    } t_ptw_walk;

endpackage

// File: design/ptw_step.sv
// Next-state and result logic for one walker transaction.
`timescale 1ns / 1ps

module ptw_step (
    input  ptw_pkg::t_ptw_walk               i_walk,
    input  ptw_pkg::t_ptw_in                 i_item,
    input  logic [ptw_pkg::FRAME_W-1:0]      i_root_frame,
    input  logic                             i_four_level,
    output ptw_pkg::t_ptw_walk               o_walk,
    output logic                             o_has_result,
    output ptw_pkg::t_ptw_out                o_result
);
    import ptw_pkg::*;

    t_ptw_walk             walk_nx;
    logic [IDX_BITS-1:0]   idx;
    logic [PA_W-1:0]       table_nx;

    always_comb begin
        walk_nx      = i_walk;
        o_has_result = 1'b0;
        o_result     = '0;
        table_nx     = '0;

        if (i_item.cmd == CMD_START) begin
            walk_nx.busy            = 1'b1;
            walk_nx.latched_address = i_item.virtual_address;
            if (i_four_level) begin
                walk_nx.level_left    = LEVELS_FOUR;
                table_nx              = {4'b0, i_root_frame[35:0], 12'b0};
            end else begin
                walk_nx.level_left    = LEVELS_THREE;
                table_nx              = {20'b0, i_root_frame[19:0], 12'b0};
            end
            walk_nx.table_address = table_nx;
            o_has_result          = 1'b1;
        end else if (i_walk.busy && (i_walk.level_left != '0)) begin
            walk_nx.table_address = {i_item.entry_data[PA_W-1:PAGE_BITS], 12'b0};
            walk_nx.level_left    = i_walk.level_left - 3'd1;
            o_has_result          = 1'b1;
            if (walk_nx.level_left == '0) begin
                walk_nx.busy   = 1'b0;
                o_result.kind  = KIND_DONE;
                o_result.frame = i_item.entry_data[PA_W-1:PAGE_BITS];
            end
        end

        // index for the level about to be read
        case (walk_nx.level_left[1:0])
            2'd0:    idx = walk_nx.latched_address[47:39];
            2'd3:    idx = walk_nx.latched_address[38:30];
            2'd2:    idx = walk_nx.latched_address[29:21];
            default: idx = walk_nx.latched_address[20:12];
        endcase

        if (o_has_result && walk_nx.busy) begin
            o_result.kind         = KIND_READ;
            o_result.read_address = walk_nx.table_address
                                  + {{(PA_W-IDX_BITS-ENTRY_SH){1'b0}}, idx, 3'b000};
        end
    end

    assign o_walk = walk_nx;

endmodule

// File: design/page_table_walker_core.sv
// Top level of the page table walker: registers, handshakes and result stage.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in_data  (cmd, va, entry)
//  out     | out | o_out_valid / i_out_ready | o_out_data (kind, addr, frame)
//  cfg     | in  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One transaction per cycle unless output stalls; a result shows in the next cycle.
// The result register is the only stage: input is taken whenever it is empty
// or being drained in the same cycle.
// Reset (synchronous, active low) idles the walker, root_frame 0, four levels.
// A response arriving with no walk in progress is dropped and gives no result.
`timescale 1ns / 1ps

module page_table_walker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ptw_pkg::t_ptw_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ptw_pkg::t_ptw_out                 o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ptw_pkg::*;

    logic [FRAME_W-1:0] r_root_frame;
    logic               r_four_level;
    t_ptw_walk          r_walk;
    t_ptw_walk          n_walk;
    logic               r_out_valid;
    t_ptw_out           r_out_data;
    t_ptw_out           n_out_data;
    logic               has_result;
    logic               in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    ptw_step u_step (
        .i_walk       (r_walk),
        .i_item       (i_in_data),
        .i_root_frame (r_root_frame),
        .i_four_level (r_four_level),
        .o_walk       (n_walk),
        .o_has_result (has_result),
        .o_result     (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame <= '0;
            r_four_level <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROOT_FRAME: r_root_frame <= i_cfg_data;
                CFG_FOUR_LEVEL: r_four_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_walk <= n_walk;
            end
            if (o_in_ready) begin
                r_out_valid <= in_fire && has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && has_result) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/ptw_checker.sv
// Port-level assertions for the page table walker, bound to the top level.
`timescale 1ns / 1ps

module ptw_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  ptw_pkg::t_ptw_in      i_in_data,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  ptw_pkg::t_ptw_out     o_out_data
);
    import ptw_pkg::*;

    // a held result must not vanish before it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // an empty result stage never blocks input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result stage");

    // every start gives a read request in the next cycle
    a_start_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd == CMD_START)
        |=> o_out_valid && (o_out_data.kind == KIND_READ))
        else $error("start without read request");

    // unused result field is zero
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.kind == KIND_READ) && (o_out_data.frame == '0))
                     || ((o_out_data.kind == KIND_DONE) && (o_out_data.read_address == '0)))
        else $error("unused result field not zero");

endmodule

bind page_table_walker_core ptw_checker u_ptw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/page_table_walker_core_tb.sv
// Self-checking testbench for page_table_walker_core: directed table, random walks, predictor.
`timescale 1ns / 1ps

module page_table_walker_core_tb;
    import ptw_pkg::*;

    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_RESULTS = 80;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned LIMIT_CYCLES  = 200000;
    localparam logic [VA_W-1:0]    VA_ONES    = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_ONES = '1;
    localparam logic [FRAME_W-1:0] FRAME_ONES = '1;

    typedef struct {
        bit                    is_reg_write;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        t_ptw_in               item;
        bit                    pinned;
        bit                    pinned_has;
        t_ptw_out              pinned_res;
    } t_walk_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_ptw_in               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_ptw_out              out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus side controls for the receiver process
    logic                  calm       = 1'b0;
    logic                  start_hold = 1'b0;
    int unsigned           hold_left  = 0;

    // predictor copy of registers and walk state
    logic [FRAME_W-1:0]    cfg_root_frame   = '0;
    logic                  cfg_four_level   = 1'b1;
    logic                  walk_busy        = 1'b0;
    logic [LEVEL_W-1:0]    walk_levels_left = '0;
    logic [PA_W-1:0]       walk_table_addr  = '0;
    logic [VA_W-1:0]       walk_va          = '0;

    t_ptw_out              expected_results[$];
    t_walk_row             directed_rows[$];
    int unsigned           failures      = 0;
    int unsigned           phase_results = 0;

    page_table_walker_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // read request for the entry of the current level
    function automatic t_ptw_out entry_request();
        t_ptw_out           req;
        logic [1:0]         lvl_sel;
        int unsigned        shift;
        logic [IDX_BITS-1:0] idx;
        lvl_sel = 2'(walk_levels_left - 3'd1);
        shift   = PAGE_BITS + IDX_BITS * lvl_sel;
        idx     = IDX_BITS'(walk_va >> shift);
        req.kind         = KIND_READ;
        req.read_address = walk_table_addr + (PA_W'(idx) << ENTRY_SH);
        req.frame        = '0;
        return req;
    endfunction

    task automatic advance_walk(input t_ptw_in item, output bit has, output t_ptw_out res);
        logic [PA_W-1:0] root;
        has  = 1'b0;
        res  = '0;
        root = {cfg_root_frame, {PAGE_BITS{1'b0}}};
        if (item.cmd == CMD_START) begin
            walk_va = item.virtual_address;
            if (cfg_four_level) begin
                walk_levels_left = LEVELS_FOUR;
                walk_table_addr  = {4'h0, root[47:0]};
            end else begin
                walk_levels_left = LEVELS_THREE;
                walk_table_addr  = {20'h0, root[31:0]};
            end
            walk_busy = 1'b1;
            has       = 1'b1;
            res       = entry_request();
        end else if (walk_busy && walk_levels_left != 0) begin
            walk_table_addr  = {item.entry_data[PA_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
            walk_levels_left = walk_levels_left - 3'd1;
            has              = 1'b1;
            if (walk_levels_left == 0) begin
                walk_busy        = 1'b0;
                res.kind         = KIND_DONE;
                res.read_address = '0;
                res.frame        = walk_table_addr[PA_W-1:PAGE_BITS];
            end else begin
                res = entry_request();
            end
        end
    endtask

    function automatic logic [63:0] wide_random();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic void add_row(logic cmd, logic [VA_W-1:0] va, logic [ENTRY_W-1:0] entry,
                                    bit pinned, bit has, logic kind,
                                    logic [PA_W-1:0] addr, logic [FRAME_W-1:0] frame);
        t_walk_row row;
        row                         = '{default: '0};
        row.item.cmd                = cmd;
        row.item.virtual_address    = va;
        row.item.entry_data         = entry;
        row.pinned                  = pinned;
        row.pinned_has              = has;
        row.pinned_res.kind         = kind;
        row.pinned_res.read_address = addr;
        row.pinned_res.frame        = frame;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        t_walk_row row;
        row              = '{default: '0};
        row.is_reg_write = 1'b1;
        row.reg_index    = idx;
        row.reg_value    = value;
        directed_rows.push_back(row);
    endfunction

    // lower valid and wait until every expected result has come and the block has settled
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_ROOT_FRAME) cfg_root_frame = value;
        else cfg_four_level = value[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_item(input t_ptw_in item, input bit pinned, input bit pinned_has,
                              input t_ptw_out pinned_res);
        bit       has;
        t_ptw_out res;
        while (!calm && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        advance_walk(item, has, res);
        if (has) phase_results++;
        if (pinned) begin
            if (pinned_has) expected_results.push_back(pinned_res);
        end else if (has) begin
            expected_results.push_back(res);
        end
    endtask

    task automatic offer_random(input logic cmd);
        t_ptw_in  item;
        logic [63:0] va_bits;
        va_bits              = wide_random();
        item.cmd             = cmd;
        item.virtual_address = va_bits[VA_W-1:0];
        item.entry_data      = wide_random();
        offer_item(item, 1'b0, 1'b0, '0);
    endtask

    task automatic check_result(input t_ptw_out got);
        t_ptw_out want;
        if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: result with nothing expected, got %h", $time, got);
        end else begin
            want = expected_results.pop_front();
            if (got != want) begin
                failures++;
                if (got.kind != want.kind)
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want.kind, got.kind);
                if (got.read_address != want.read_address)
                    $display("%0t: read_address expected %h actual %h",
                             $time, want.read_address, got.read_address);
                if (got.frame != want.frame)
                    $display("%0t: frame expected %h actual %h",
                             $time, want.frame, got.frame);
            end
        end
    endtask

    // result side: checks each transaction and drives ready, with an occasional long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (out_valid && out_ready) check_result(out_data);
            if (start_hold) hold_left <= HOLD_CYCLES;
            else if (hold_left != 0) hold_left <= hold_left - 1;
            out_ready <= !start_hold && hold_left <= 1 && (calm || $urandom_range(99) >= 16);
        end
    end

    initial begin
        int unsigned  levels;
        int unsigned  pick;
        int unsigned  resp_count;
        logic [63:0]  root_bits;
        logic [63:0]  mode_bits;
        logic         mode;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: root 0, four levels
        add_row(CMD_RESP,  '0, '0, 1, 0, KIND_READ, '0, '0);  // response while idle
        add_row(CMD_START, '0, '0, 1, 1, KIND_READ, '0, '0);
        add_row(CMD_RESP,  '0, ENTRY_ONES, 1, 1, KIND_READ, 52'hF_FFFF_FFFF_F000, '0);
        add_row(CMD_RESP,  '0, '0, 1, 1, KIND_READ, '0, '0);
        add_row(CMD_RESP,  '0, ENTRY_ONES, 1, 1, KIND_READ, 52'hF_FFFF_FFFF_F000, '0);
        add_row(CMD_RESP,  '0, ENTRY_ONES, 1, 1, KIND_DONE, '0, FRAME_ONES);
        add_row(CMD_RESP,  VA_ONES, ENTRY_ONES, 1, 0, KIND_READ, '0, '0);
        add_row(CMD_START, VA_ONES, '0, 1, 1, KIND_READ, 52'h0_0000_0000_0FF8, '0);
        // start while busy abandons the walk
        add_row(CMD_START, 48'h1234_5678_9ABC, '0, 0, 0, KIND_READ, '0, '0);
        add_row(CMD_RESP,  '0, 64'hA5A5_5A5A_C3C3_3C3C, 0, 0, KIND_READ, '0, '0);
        add_row(CMD_RESP,  '0, 64'h0000_0000_0000_0FFF, 0, 0, KIND_READ, '0, '0);
        // registers change mid walk; the walk carries on with the old setting
        add_reg_row(CFG_ROOT_FRAME, FRAME_ONES);
        add_reg_row(CFG_FOUR_LEVEL, '0);
        add_row(CMD_RESP,  '0, 64'h8000_0000_0000_1000, 0, 0, KIND_READ, '0, '0);
        add_row(CMD_RESP,  '0, 64'h7FF0_0000_0000_0000, 0, 0, KIND_READ, '0, '0);
        // three levels, root truncated to 32 bits
        add_row(CMD_START, VA_ONES, '0, 1, 1, KIND_READ, 52'h0_0000_FFFF_FFF8, '0);
        add_row(CMD_RESP,  '0, ENTRY_ONES, 1, 1, KIND_READ, 52'hF_FFFF_FFFF_FFF8, '0);
        add_row(CMD_RESP,  '0, ENTRY_ONES, 1, 1, KIND_READ, 52'hF_FFFF_FFFF_FFF8, '0);
        add_row(CMD_RESP,  '0, ENTRY_ONES, 1, 1, KIND_DONE, '0, FRAME_ONES);
        // four levels, root clamped to 48 bits
        add_reg_row(CFG_FOUR_LEVEL, 40'h1);
        add_row(CMD_START, '0, '0, 1, 1, KIND_READ, 52'h0_FFFF_FFFF_F000, '0);
        add_row(CMD_RESP,  '0, 64'h0123_4567_89AB_CDEF, 0, 0, KIND_READ, '0, '0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_reg_write)
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                offer_item(directed_rows[i].item, directed_rows[i].pinned,
                           directed_rows[i].pinned_has, directed_rows[i].pinned_res);
        end

        for (int p = 0; p < PHASES; p++) begin
            root_bits = {$urandom, $urandom};
            mode_bits = {$urandom, $urandom};
            case (p % 4)
                0: begin root_bits = '0; mode = 1'b1; end
                1: begin root_bits = '1; mode = 1'b0; end
                default: mode = 1'($urandom_range(1));
            endcase
            write_register(CFG_ROOT_FRAME, root_bits[CFG_DATA_W-1:0]);
            write_register(CFG_FOUR_LEVEL, {mode_bits[CFG_DATA_W-1:1], mode});
            calm <= (p == 3);
            if (p == 5) begin
                start_hold <= 1'b1;
                @(posedge clk);
                start_hold <= 1'b0;
            end
            phase_results = 0;
            while (phase_results < PHASE_RESULTS) begin
                levels = cfg_four_level ? 4 : 3;
                pick   = $urandom_range(99);
                if (pick < 8) begin
                    offer_random(CMD_RESP);  // stray response
                end else begin
                    resp_count = (pick < 18) ? $urandom_range(levels - 1) : levels;
                    offer_random(CMD_START);
                    repeat (resp_count) offer_random(CMD_RESP);
                end
            end
        end

        drain_pipeline();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/ptw_pkg.sv
design/ptw_step.sv
design/page_table_walker_core.sv
design/ptw_checker.sv
tb/page_table_walker_core_tb.sv
